[hdl/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg
// Shared sizes, codes and types for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int GROUP         = 8;
    localparam int N_GROUPS      = (TABLE_ENTRIES + GROUP - 1) / GROUP;

    localparam int KEY_W  = 31;
    localparam int QTY_W  = 24;
    localparam int DATA_W = 56;

    localparam logic signed [QTY_W-1:0] QTY_MAX = 24'sh7FFFFF;
    localparam logic signed [QTY_W-1:0] QTY_MIN = -24'sh800000;

    // commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_DUMP   = 2'd3;

    // result status
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // cell operations
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_CMP  = 3'd1;
    localparam logic [2:0] OP_INS  = 3'd2;
    localparam logic [2:0] OP_UPD  = 3'd3;
    localparam logic [2:0] OP_ROT  = 3'd4;

    typedef struct packed {
        logic [2:0]              op;
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] qty;
    } t_cell_ctl;

endpackage

[hdl/krt_cell.sv]
// ----------------------------------------------------------------------------
// krt_cell
// One slot of the sorted record chain: compares, shifts up on insert,
// updates in place and rotates towards the head during a dump.
// ----------------------------------------------------------------------------
module krt_cell (
    input  logic                               i_clk,
    input  krt_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_valid,
    input  logic                               i_wrap,
    input  logic                               i_left_lt,
    input  logic [krt_pkg::KEY_W-1:0]          i_left_key,
    input  logic signed [krt_pkg::QTY_W-1:0]   i_left_qty,
    input  logic [krt_pkg::KEY_W-1:0]          i_right_key,
    input  logic signed [krt_pkg::QTY_W-1:0]   i_right_qty,
    input  logic [krt_pkg::KEY_W-1:0]          i_head_key,
    input  logic signed [krt_pkg::QTY_W-1:0]   i_head_qty,
    output logic [krt_pkg::KEY_W-1:0]          o_key,
    output logic signed [krt_pkg::QTY_W-1:0]   o_qty,
    output logic                               o_lt,
    output logic                               o_eq
);

    logic [krt_pkg::KEY_W-1:0]        r_key;
    logic signed [krt_pkg::QTY_W-1:0] r_qty;
    logic                             r_lt;
    logic                             r_eq;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            krt_pkg::OP_CMP: begin
                r_lt <= i_valid && (r_key < i_ctl.key);
                r_eq <= i_valid && (r_key == i_ctl.key);
            end
            krt_pkg::OP_INS: begin
                // open the gap at the first slot not below the new key
                if (!r_lt && i_left_lt) begin
                    r_key <= i_ctl.key;
                    r_qty <= i_ctl.qty;
                end else if (!i_left_lt) begin
                    r_key <= i_left_key;
                    r_qty <= i_left_qty;
                end
            end
            krt_pkg::OP_UPD: begin
                if (r_eq) begin
                    r_qty <= i_ctl.qty;
                end
            end
            krt_pkg::OP_ROT: begin
                if (i_valid) begin
                    r_key <= i_wrap ? i_head_key : i_right_key;
                    r_qty <= i_wrap ? i_head_qty : i_right_qty;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key = r_key;
    assign o_qty = r_qty;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

[hdl/keyed_record_table_sorted_dump.sv]
// ----------------------------------------------------------------------------
// keyed_record_table_sorted_dump
// Sorted record table built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Holds up to 64 records in a chain of cells kept in ascending key order.
// Insert, lookup and update go from acceptance to result in order: every
// cell compares its key with the command key, the registered OR tree
// gathers match flags and the matching quantity, first within groups and
// then across groups, the decision is made, and the result word then goes
// out while the chain shifts or updates. A dump emits one record per cycle
// from the head cell, unless the sink stalls the output, while the valid
// part of the chain rotates, and the table is back in order when it ends.
// A new command is taken only once the previous one has been written to the
// output register; the output register lets the final word wait for the sink.
module keyed_record_table_sorted_dump (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [krt_pkg::DATA_W-1:0]   i_s_tdata,   // part_key, quantity_value, pad
    input  logic [1:0]                   i_s_tuser,   // cmd
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [krt_pkg::DATA_W-1:0]   o_m_tdata,   // record_key, record_quantity, pad
    output logic [2:0]                   o_m_tuser,   // status
    output logic                         o_m_tlast    // last_of_run
);

    localparam int N  = krt_pkg::TABLE_ENTRIES;
    localparam int KW = krt_pkg::KEY_W;
    localparam int QW = krt_pkg::QTY_W;
    localparam int CW = krt_pkg::CNT_W;
    localparam int IW = krt_pkg::IDX_W;
    localparam int NG = krt_pkg::N_GROUPS;
    localparam int G  = krt_pkg::GROUP;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_GRP  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_DUMP = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_cmd;
    logic [KW-1:0]        r_key;
    logic signed [QW-1:0] r_qv;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_didx, n_didx;

    logic [NG-1:0]        r_grp_eq;
    logic [QW-1:0]        r_grp_qty [NG];
    logic                 r_found;
    logic signed [QW-1:0] r_fqty;

    logic                 r_m_valid, n_m_valid;
    logic [KW-1:0]        r_m_key, n_m_key;
    logic signed [QW-1:0] r_m_qty, n_m_qty;
    logic [2:0]           r_m_status, n_m_status;
    logic                 r_m_last, n_m_last;

    logic                 w_accept;
    logic                 w_adv;
    logic                 w_full;
    logic [QW:0]          w_sum;
    logic signed [QW-1:0] w_sat;
    krt_pkg::t_cell_ctl   w_ctl;

    logic [KW-1:0]        w_key [N];
    logic signed [QW-1:0] w_qty [N];
    logic [N-1:0]         w_lt;
    logic [N-1:0]         w_eq;
    logic [N-1:0]         w_valid;
    logic [N-1:0]         w_wrap;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_adv    = !r_m_valid || i_m_tready;
    assign w_full   = (r_count == CW'(N));

    // saturating add of the change to the found quantity
    assign w_sum = {r_fqty[QW-1], r_fqty} + {r_qv[QW-1], r_qv};
    always_comb begin
        if (w_sum[QW] != w_sum[QW-1]) begin
            w_sat = w_sum[QW] ? krt_pkg::QTY_MIN : krt_pkg::QTY_MAX;
        end else begin
            w_sat = w_sum[QW-1:0];
        end
    end

    // chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            assign w_valid[gi] = (CW'(gi) < r_count);
            assign w_wrap[gi]  = (CW'(gi + 1) == r_count);

            krt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_valid[gi]),
                .i_wrap      (w_wrap[gi]),
                .i_left_lt   ((gi == 0) ? 1'b1 : w_lt[(gi == 0) ? 0 : gi - 1]),
                .i_left_key  (w_key[(gi == 0) ? 0 : gi - 1]),
                .i_left_qty  (w_qty[(gi == 0) ? 0 : gi - 1]),
                .i_right_key (w_key[(gi == N - 1) ? 0 : gi + 1]),
                .i_right_qty (w_qty[(gi == N - 1) ? 0 : gi + 1]),
                .i_head_key  (w_key[0]),
                .i_head_qty  (w_qty[0]),
                .o_key       (w_key[gi]),
                .o_qty       (w_qty[gi]),
                .o_lt        (w_lt[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    // registered match tree: groups first, then across groups
    always_ff @(posedge i_clk) begin
        logic          v_eq;
        logic [QW-1:0] v_q;
        if (r_state == S_GRP) begin
            for (int g = 0; g < NG; g++) begin
                v_eq = 1'b0;
                v_q  = '0;
                for (int j = 0; j < G; j++) begin
                    if (g * G + j < N) begin
                        v_eq = v_eq | w_eq[g*G+j];
                        v_q  = v_q | (w_qty[g*G+j] & {QW{w_eq[g*G+j]}});
                    end
                end
                r_grp_eq[g]  <= v_eq;
                r_grp_qty[g] <= v_q;
            end
        end
        if (r_state == S_FIN) begin
            v_q = '0;
            for (int g = 0; g < NG; g++) begin
                v_q = v_q | r_grp_qty[g];
            end
            r_found <= |r_grp_eq;
            r_fqty  <= v_q;
        end
    end

    // control and result path
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_didx     = r_didx;
        n_m_valid  = r_m_valid;
        n_m_key    = r_m_key;
        n_m_qty    = r_m_qty;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;
        w_ctl.op   = krt_pkg::OP_HOLD;
        w_ctl.key  = r_key;
        w_ctl.qty  = r_qv;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_tuser == krt_pkg::CMD_DUMP) ? S_DUMP : S_CMP;
                    n_didx  = '0;
                end
            end
            S_CMP: begin
                w_ctl.op = krt_pkg::OP_CMP;
                n_state  = S_GRP;
            end
            S_GRP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_adv) begin
                    n_m_valid  = 1'b1;
                    n_m_key    = r_key;
                    n_m_qty    = '0;
                    n_m_last   = 1'b1;
                    n_m_status = krt_pkg::ST_OK;
                    n_state    = S_IDLE;
                    case (r_cmd)
                        krt_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_m_status = krt_pkg::ST_FULL;
                            end else if (r_found) begin
                                n_m_status = krt_pkg::ST_DUP;
                            end else begin
                                n_m_qty  = r_qv;
                                w_ctl.op = krt_pkg::OP_INS;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        krt_pkg::CMD_LOOKUP: begin
                            if (r_found) begin
                                n_m_qty = r_fqty;
                            end else begin
                                n_m_status = krt_pkg::ST_MISSING;
                            end
                        end
                        krt_pkg::CMD_UPDATE: begin
                            if (r_found) begin
                                n_m_qty   = w_sat;
                                w_ctl.op  = krt_pkg::OP_UPD;
                                w_ctl.qty = w_sat;
                            end else begin
                                n_m_status = krt_pkg::ST_MISSING;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_adv) begin
                    n_m_valid = 1'b1;
                    if (r_count == '0) begin
                        n_m_status = krt_pkg::ST_EMPTY;
                        n_m_key    = '0;
                        n_m_qty    = '0;
                        n_m_last   = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        // emit the head and rotate the valid run one place towards the head
                        n_m_status = krt_pkg::ST_OK;
                        n_m_key    = w_key[0];
                        n_m_qty    = w_qty[0];
                        n_m_last   = ({1'b0, r_didx} == r_count - CW'(1));
                        w_ctl.op   = krt_pkg::OP_ROT;
                        n_didx     = r_didx + IW'(1);
                        if (n_m_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_didx    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_didx    <= n_didx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_s_tuser;
            r_key <= i_s_tdata[KW-1:0];
            r_qv  <= i_s_tdata[KW+QW-1:KW];
        end
        r_m_key    <= n_m_key;
        r_m_qty    <= n_m_qty;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(krt_pkg::DATA_W - KW - QW){1'b0}}, r_m_qty, r_m_key};
    assign o_m_tuser  = r_m_status;
    assign o_m_tlast  = r_m_last;

endmodule
